// ===== rtl/mlf_pkg.sv =====
// Package for the MAC learning forwarder: sizes, word types, codes and helpers.
package mlf_pkg;

    localparam int NUM_PORTS   = 8;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PORT_W      = 3;
    localparam int MAC_W       = 48;
    localparam int MASK_W      = 8;

    // Mask of every port that exists
    localparam logic [MASK_W-1:0] ALL_PORTS = MASK_W'((1 << NUM_PORTS) - 1);

    // Last table index, used for the replace pointer wrap
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_FWD    = 2'd0,
        ACT_DROP   = 2'd1,
        ACT_ROUTER = 2'd2,
        ACT_FLOOD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_DELIVER
    } t_state;

    // Input word: one frame header
    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] arrival_port;
        logic              src_present;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dest_mac;
    } t_in_word;

    // Output word: forwarding decision
    typedef struct packed {
        logic [MASK_W-1:0] port_mask;
        t_action           action;
    } t_out_word;

    // Query token that walks down the cell row
    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] arrival_port;
        logic              learn;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dest_mac;
        logic              src_done;
        logic              dest_hit;
        logic [PORT_W-1:0] dest_port;
        logic [IDX_W-1:0]  dest_idx;
    } t_token;

    // Direct entry write, used for replacement in a full table
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_wr_req;

    // One-hot bit for a port, zero for a port that does not exist
    function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] port);
        logic [MASK_W-1:0] bitv;
        bitv = '0;
        if (32'(port) < NUM_PORTS) begin
            bitv = MASK_W'(1) << port;
        end
        return bitv;
    endfunction

endpackage

// ===== rtl/mlf_cell.sv =====
// One table entry cell: holds a MAC/port pair and passes the query token on.
module mlf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mlf_pkg::IDX_W-1:0]     i_index,
    input  logic                          i_tok_vld,
    input  mlf_pkg::t_token               i_tok,
    input  mlf_pkg::t_wr_req              i_wr,
    output logic                          o_tok_vld,
    output mlf_pkg::t_token               o_tok
);

    logic                         r_valid;
    logic                         n_valid;
    logic [mlf_pkg::MAC_W-1:0]    r_mac;
    logic [mlf_pkg::MAC_W-1:0]    n_mac;
    logic [mlf_pkg::PORT_W-1:0]   r_port;
    logic [mlf_pkg::PORT_W-1:0]   n_port;
    logic                         r_tok_vld;
    mlf_pkg::t_token              r_tok;
    mlf_pkg::t_token              n_tok;

    logic pend;
    logic upd;
    logic fill;
    logic dmatch;

    // Learn, fill and lookup against this entry
    always_comb begin
        pend   = i_tok.learn && !i_tok.src_done;
        upd    = i_tok_vld && pend && r_valid && (r_mac == i_tok.src_mac);
        fill   = i_tok_vld && pend && !r_valid;
        dmatch = r_valid && (r_mac == i_tok.dest_mac);

        n_tok = i_tok;
        if (upd || fill) begin
            n_tok.src_done = 1'b1;
        end
        if (dmatch) begin
            n_tok.dest_hit  = 1'b1;
            n_tok.dest_port = r_port;
            n_tok.dest_idx  = i_index;
        end

        n_valid = r_valid;
        n_mac   = r_mac;
        n_port  = r_port;
        if (fill) begin
            n_valid = 1'b1;
            n_mac   = i_tok.src_mac;
            n_port  = i_tok.arrival_port;
        end else if (upd) begin
            n_port  = i_tok.arrival_port;
        end else if (i_wr.en && (i_wr.idx == i_index)) begin
            n_mac   = i_wr.mac;
            n_port  = i_wr.port;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok_vld <= i_tok_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_mac  <= n_mac;
        r_port <= n_port;
        r_tok  <= n_tok;
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

// ===== rtl/mlf_resolve.sv =====
// Turns a finished token into the forwarding decision and the replacement request.
module mlf_resolve (
    input  mlf_pkg::t_token               i_tok,
    input  logic [mlf_pkg::IDX_W-1:0]     i_rep_ptr,
    input  logic [mlf_pkg::PORT_W-1:0]    i_router_port,
    output mlf_pkg::t_wr_req              o_wr,
    output mlf_pkg::t_out_word            o_word
);

    logic evict;
    logic hit;

    always_comb begin
        // Source still unlearned after the whole row: table is full
        evict = i_tok.learn && !i_tok.src_done;
        hit   = i_tok.dest_hit && !(evict && (i_tok.dest_idx == i_rep_ptr));

        o_wr.en   = evict;
        o_wr.idx  = i_rep_ptr;
        o_wr.mac  = i_tok.src_mac;
        o_wr.port = i_tok.arrival_port;

        if (i_tok.kind) begin
            o_word.port_mask = mlf_pkg::ALL_PORTS & ~mlf_pkg::port_bit(i_tok.arrival_port);
            o_word.action    = mlf_pkg::ACT_FLOOD;
        end else if (i_tok.learn && (i_tok.src_mac == i_tok.dest_mac)) begin
            // Destination is the source just learned: same port
            o_word.port_mask = '0;
            o_word.action    = mlf_pkg::ACT_DROP;
        end else if (hit && (i_tok.dest_port == i_tok.arrival_port)) begin
            o_word.port_mask = '0;
            o_word.action    = mlf_pkg::ACT_DROP;
        end else if (hit) begin
            o_word.port_mask = mlf_pkg::port_bit(i_tok.dest_port);
            o_word.action    = mlf_pkg::ACT_FWD;
        end else begin
            o_word.port_mask = mlf_pkg::port_bit(i_router_port);
            o_word.action    = mlf_pkg::ACT_ROUTER;
        end
    end

endmodule

// ===== rtl/mac_learning_forwarder_top.sv =====
// Top level of the MAC learning forwarder: cell row, sequencer and output register.
//
// Learning bridge over a table of TABLE_DEPTH MAC-to-port entries.
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one frame header
// per word. Output channel (o_out_valid / i_out_stall / o_out_word) returns
// exactly one decision word per header: port mask plus action code.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the router
// port; it is always ready and should be written only while the block is idle.
// A header enters a row of TABLE_DEPTH cells as a token and moves one cell per
// cycle; each cell learns and looks up against its own entry. The token is then
// captured, the resolve state works out the result (and replaces an entry when
// the table is full), and the deliver state loads the output register once it
// is free. Only one header is in the row at a time: the next header is accepted
// only after the previous decision has been loaded into the output register.
// Reset clears the table, the replace pointer and the router port (to 0);
// the table is usable right after reset. A stalled output holds its word; the
// next header is accepted and walks the row meanwhile, then waits for the slot.
module mac_learning_forwarder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mlf_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mlf_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mlf_pkg::PORT_W-1:0]    i_cfg_data
);

    mlf_pkg::t_state               r_state;
    mlf_pkg::t_state               n_state;
    logic [mlf_pkg::PORT_W-1:0]    r_router_port;
    logic [mlf_pkg::IDX_W-1:0]     r_rep_ptr;
    logic                          r_inj_vld;
    mlf_pkg::t_token               r_inj;
    mlf_pkg::t_token               n_inj;
    mlf_pkg::t_token               r_end;
    mlf_pkg::t_out_word            r_res;
    logic                          r_out_vld;
    mlf_pkg::t_out_word            r_out;

    logic                          in_acc;
    logic                          end_cap;
    logic                          do_resolve;
    logic                          out_load;
    logic                          out_free;

    logic                          chain_vld [mlf_pkg::TABLE_DEPTH+1];
    mlf_pkg::t_token               chain_tok [mlf_pkg::TABLE_DEPTH+1];
    mlf_pkg::t_wr_req              res_wr;
    mlf_pkg::t_wr_req              cell_wr;
    mlf_pkg::t_out_word            res_word;

    assign out_free = !r_out_vld || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mlf_pkg::ST_SCAN;
                end
            end
            mlf_pkg::ST_SCAN: begin
                if (chain_vld[mlf_pkg::TABLE_DEPTH]) begin
                    n_state = mlf_pkg::ST_RESOLVE;
                end
            end
            mlf_pkg::ST_RESOLVE: begin
                n_state = mlf_pkg::ST_DELIVER;
            end
            mlf_pkg::ST_DELIVER: begin
                if (out_free) begin
                    n_state = mlf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mlf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        in_acc     = 1'b0;
        end_cap    = 1'b0;
        do_resolve = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            mlf_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                in_acc     = i_in_valid;
            end
            mlf_pkg::ST_SCAN: begin
                end_cap = chain_vld[mlf_pkg::TABLE_DEPTH];
            end
            mlf_pkg::ST_RESOLVE: begin
                do_resolve = 1'b1;
            end
            mlf_pkg::ST_DELIVER: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Build the token from the accepted header
    always_comb begin
        n_inj              = '0;
        n_inj.kind         = i_in_word.kind;
        n_inj.arrival_port = i_in_word.arrival_port;
        n_inj.learn        = i_in_word.src_present && !i_in_word.kind;
        n_inj.src_mac      = i_in_word.src_mac;
        n_inj.dest_mac     = i_in_word.dest_mac;
    end

    assign chain_vld[0] = r_inj_vld;
    assign chain_tok[0] = r_inj;

    // Replacement write goes out only in the resolve cycle
    always_comb begin
        cell_wr    = res_wr;
        cell_wr.en = res_wr.en && do_resolve;
    end

    // Row of table cells
    for (genvar g = 0; g < mlf_pkg::TABLE_DEPTH; g++) begin : g_cell
        mlf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (mlf_pkg::IDX_W'(g)),
            .i_tok_vld (chain_vld[g]),
            .i_tok     (chain_tok[g]),
            .i_wr      (cell_wr),
            .o_tok_vld (chain_vld[g+1]),
            .o_tok     (chain_tok[g+1])
        );
    end

    mlf_resolve u_resolve (
        .i_tok         (r_end),
        .i_rep_ptr     (r_rep_ptr),
        .i_router_port (r_router_port),
        .o_wr          (res_wr),
        .o_word        (res_word)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mlf_pkg::ST_IDLE;
            r_router_port <= '0;
            r_rep_ptr     <= '0;
            r_inj_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj_vld <= in_acc;
            if (i_cfg_valid) begin
                r_router_port <= i_cfg_data;
            end
            if (cell_wr.en) begin
                if (r_rep_ptr == mlf_pkg::LAST_IDX) begin
                    r_rep_ptr <= '0;
                end else begin
                    r_rep_ptr <= r_rep_ptr + 1'b1;
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_inj <= n_inj;
        end
        if (end_cap) begin
            r_end <= chain_tok[mlf_pkg::TABLE_DEPTH];
        end
        if (do_resolve) begin
            r_res <= res_word;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ===== tb/mac_learning_forwarder_top_tb.sv =====
// Self-checking testbench for the MAC learning forwarder: header stimulus, table predictor, checks.
module mac_learning_forwarder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected-decision tracker: mirrors the MAC table and queues one decision per header
    class mac_table_scoreboard;
        bit                         slot_valid[mlf_pkg::TABLE_DEPTH];
        logic [mlf_pkg::MAC_W-1:0]  slot_mac[mlf_pkg::TABLE_DEPTH];
        logic [mlf_pkg::PORT_W-1:0] slot_port[mlf_pkg::TABLE_DEPTH];
        int unsigned                evict_ptr;
        logic [mlf_pkg::PORT_W-1:0] router_port;
        mlf_pkg::t_out_word         decisions_due[$];
        int unsigned                errors;
        int unsigned                headers;
        int unsigned                decisions;
        int unsigned                evictions;
        int unsigned                router_writes;
        int unsigned                action_count[4];

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            evict_ptr     = 0;
            router_port   = '0;
            errors        = 0;
            headers       = 0;
            decisions     = 0;
            evictions     = 0;
            router_writes = 0;
            foreach (action_count[i]) action_count[i] = 0;
        endfunction

        function void set_router(logic [mlf_pkg::PORT_W-1:0] port);
            router_port = port;
            router_writes++;
        endfunction

        function int find_slot(logic [mlf_pkg::MAC_W-1:0] mac);
            int i;
            for (i = 0; i < mlf_pkg::TABLE_DEPTH; i++) begin
                if (slot_valid[i] && slot_mac[i] == mac) return i;
            end
            return -1;
        endfunction

        // Ports past NUM_PORTS never show up in a mask
        function logic [mlf_pkg::MASK_W-1:0] port_onehot(logic [mlf_pkg::PORT_W-1:0] port);
            if (int'(port) >= mlf_pkg::NUM_PORTS) return '0;
            return mlf_pkg::MASK_W'(1) << port;
        endfunction

        // Known address: update in place; else lowest free slot; else round-robin victim
        function void learn_source(logic [mlf_pkg::MAC_W-1:0] mac,
                                   logic [mlf_pkg::PORT_W-1:0] port);
            int slot;
            int i;
            slot = find_slot(mac);
            if (slot < 0) begin
                for (i = 0; i < mlf_pkg::TABLE_DEPTH; i++) begin
                    if (slot < 0 && !slot_valid[i]) slot = i;
                end
            end
            if (slot < 0) begin
                slot      = evict_ptr;
                evict_ptr = (evict_ptr + 1) % mlf_pkg::TABLE_DEPTH;
                evictions++;
            end
            slot_valid[slot] = 1'b1;
            slot_mac[slot]   = mac;
            slot_port[slot]  = port;
        endfunction

        // Called once per accepted header word
        function void note_header(mlf_pkg::t_in_word hdr);
            mlf_pkg::t_out_word want;
            int                 hit;
            if (hdr.kind) begin
                want.port_mask = mlf_pkg::ALL_PORTS & ~port_onehot(hdr.arrival_port);
                want.action    = mlf_pkg::ACT_FLOOD;
            end else begin
                if (hdr.src_present) learn_source(hdr.src_mac, hdr.arrival_port);
                hit = find_slot(hdr.dest_mac);
                if (hit < 0) begin
                    want.port_mask = port_onehot(router_port);
                    want.action    = mlf_pkg::ACT_ROUTER;
                end else if (slot_port[hit] == hdr.arrival_port) begin
                    want.port_mask = '0;
                    want.action    = mlf_pkg::ACT_DROP;
                end else begin
                    want.port_mask = port_onehot(slot_port[hit]);
                    want.action    = mlf_pkg::ACT_FWD;
                end
            end
            decisions_due.push_back(want);
            headers++;
        endfunction

        // Called once per accepted decision word
        function void check_decision(mlf_pkg::t_out_word got);
            mlf_pkg::t_out_word want;
            decisions++;
            if (decisions_due.size() == 0) begin
                errors++;
                $error("decision with none expected: port_mask %02h action %0d",
                       got.port_mask, got.action);
                return;
            end
            want = decisions_due.pop_front();
            if (got.port_mask !== want.port_mask) begin
                errors++;
                $error("port_mask expected %02h actual %02h", want.port_mask, got.port_mask);
            end
            if (got.action !== want.action) begin
                errors++;
                $error("action expected %0d actual %0d", want.action, got.action);
            end
            action_count[want.action]++;
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    mlf_pkg::t_in_word          i_in_word   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    mlf_pkg::t_out_word         o_out_word;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [mlf_pkg::PORT_W-1:0] i_cfg_data  = '0;

    mac_table_scoreboard        sb = new();
    bit                         hold_req = 1'b0;
    logic [mlf_pkg::MAC_W-1:0]  mac_pool[256];

    mac_learning_forwarder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [mlf_pkg::MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[mlf_pkg::MAC_W-1:0];
    endfunction

    function automatic mlf_pkg::t_in_word mk_header(logic kind,
                                                    logic [mlf_pkg::PORT_W-1:0] port,
                                                    logic sp,
                                                    logic [mlf_pkg::MAC_W-1:0] src,
                                                    logic [mlf_pkg::MAC_W-1:0] dst);
        mlf_pkg::t_in_word w;
        w.kind         = kind;
        w.arrival_port = port;
        w.src_present  = sp;
        w.src_mac      = src;
        w.dest_mac     = dst;
        return w;
    endfunction

    // Mostly addresses from a shared pool so learns and lookups meet; some fully random
    function automatic mlf_pkg::t_in_word rand_header(int pool_n);
        mlf_pkg::t_in_word w;
        w.kind         = ($urandom_range(0, 99) < 8);
        w.arrival_port = mlf_pkg::PORT_W'($urandom_range(0, 7));
        w.src_present  = ($urandom_range(0, 99) < 85);
        w.src_mac      = ($urandom_range(0, 99) < 90) ? mac_pool[$urandom_range(0, pool_n - 1)]
                                                       : rand_mac();
        if ($urandom_range(0, 99) < 6) begin
            w.dest_mac = w.src_mac;
        end else if ($urandom_range(0, 99) < 85) begin
            w.dest_mac = mac_pool[$urandom_range(0, pool_n - 1)];
        end else begin
            w.dest_mac = rand_mac();
        end
        return w;
    endfunction

    // Hold the word until the block takes it; valid stays up for the caller
    task automatic send_header(mlf_pkg::t_in_word hdr);
        i_in_valid <= 1'b1;
        i_in_word  <= hdr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_header(hdr);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.decisions_due.size() != 0) @(posedge i_clk);
    endtask

    // Router port write, only with nothing in flight
    task automatic write_router(logic [mlf_pkg::PORT_W-1:0] port);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= port;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_router(port);
    endtask

    // Bursts of headers with gaps of random length, long ones now and then
    task automatic run_phase(int pool_n, int n);
        int sent;
        int burst;
        int k;
        int r;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < n; k++) begin
                send_header(rand_header(pool_n));
                sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 40) idle_gap(0);
            else if (r < 90) idle_gap($urandom_range(1, 5));
            else idle_gap($urandom_range(20, 90));
        end
    endtask

    task automatic run_directed();
        logic [mlf_pkg::MAC_W-1:0] mac_a;
        logic [mlf_pkg::MAC_W-1:0] mac_b;
        logic [mlf_pkg::MAC_W-1:0] mac_c;
        logic [mlf_pkg::MAC_W-1:0] mac_d;
        logic [mlf_pkg::MAC_W-1:0] mac_e;
        mac_a = '0;
        mac_b = '1;
        mac_c = 48'h0242_ac11_0002;
        mac_d = 48'ha5a5_5a5a_f00f;
        mac_e = 48'h8000_0000_0001;
        // floods from both end ports
        send_header(mk_header(1'b1, 3'd0, 1'b1, mac_b, mac_b));
        send_header(mk_header(1'b1, 3'd7, 1'b0, mac_a, mac_a));
        // miss without learning, then learn and look up
        send_header(mk_header(1'b0, 3'd4, 1'b0, mac_c, mac_d));
        send_header(mk_header(1'b0, 3'd3, 1'b1, mac_a, mac_b));
        send_header(mk_header(1'b0, 3'd5, 1'b1, mac_b, mac_a));
        // hit on the arrival port drops
        send_header(mk_header(1'b0, 3'd3, 1'b0, mac_d, mac_a));
        // destination equal to the source just learned
        send_header(mk_header(1'b0, 3'd2, 1'b1, mac_c, mac_c));
        // known address moves to a new port
        send_header(mk_header(1'b0, 3'd6, 1'b1, mac_a, mac_b));
        send_header(mk_header(1'b0, 3'd1, 1'b0, mac_c, mac_a));
        // miss where router port equals arrival port
        send_header(mk_header(1'b0, 3'd0, 1'b1, mac_d, mac_e));
        // a flood must not learn its source
        send_header(mk_header(1'b1, 3'd3, 1'b1, mac_c, mac_d));
        send_header(mk_header(1'b0, 3'd4, 1'b0, mac_a, mac_c));
        send_header(mk_header(1'b0, 3'd7, 1'b0, mac_a, mac_d));
        write_router(3'd7);
        send_header(mk_header(1'b0, 3'd7, 1'b0, mac_b, 48'h1234_5678_9abc));
        send_header(mk_header(1'b0, 3'd0, 1'b0, mac_a, 48'h1234_5678_9abc));
        send_header(mk_header(1'b0, 3'd2, 1'b1, mac_e, mac_e));
    endtask

    // Receiver: checks every accepted decision, stalls on shifting patterns
    initial begin : rx_side
        int  mode;
        int  mode_left;
        int  hold_left;
        int  cyc;
        logic stall;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) sb.check_decision(o_out_word);
            if (hold_req) begin
                hold_left = 600;
                hold_req  = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else begin
                case (mode)
                    0: stall = 1'b0;
                    1: stall = ($urandom_range(0, 99) < 30);
                    2: stall = ((cyc % 5) < 2);
                    default: stall = ($urandom_range(0, 99) < 70);
                endcase
            end
            i_out_stall <= stall;
        end
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("mac_learning_forwarder_top_tb failed");
        $finish;
    end

    initial begin : main_flow
        int i;
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (i = 2; i < 256; i++) mac_pool[i] = rand_mac();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // small pool: mostly hits and same-port drops
        write_router(3'd0);
        run_phase(24, 300);

        // table fills; receiver holds off long enough to back up the input
        write_router(mlf_pkg::PORT_W'($urandom_range(1, 6)));
        hold_req = 1'b1;
        run_phase(100, 400);

        // heavy replacement churn
        write_router(3'd3);
        run_phase(200, 350);

        write_router(mlf_pkg::PORT_W'($urandom_range(0, 7)));
        run_phase(70, 350);

        wait_drained();
        repeat (80) @(posedge i_clk);

        $display("Run covered %0d headers, %0d decisions: %0d forwarded, %0d dropped,",
                 sb.headers, sb.decisions, sb.action_count[mlf_pkg::ACT_FWD],
                 sb.action_count[mlf_pkg::ACT_DROP]);
        $display("%0d routed, %0d flooded; full-table replacements %0d, router writes %0d.",
                 sb.action_count[mlf_pkg::ACT_ROUTER], sb.action_count[mlf_pkg::ACT_FLOOD],
                 sb.evictions, sb.router_writes);
        if (sb.errors == 0 && sb.decisions_due.size() == 0) begin
            $display("mac_learning_forwarder_top_tb passed");
        end else begin
            $display("mac_learning_forwarder_top_tb failed");
        end
        $finish;
    end

endmodule
